// ===== hw/rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared constants, register indexes, opcodes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int DEF_CORDIC_STEPS = 24;
    localparam int DEF_POSE_BITS    = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TRACK   = 1'b1;

    localparam logic OP_SPEED = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [15:0] SPEED_SCALE_RST = 16'd6554;
    localparam logic [23:0] INV_TRACK_RST   = 24'd123654;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;

    function automatic logic [29:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v[29:0];
    endfunction

endpackage

// ===== hw/rtl/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose tracker for a two-wheel base, built around one shared
// multiplier and an iterative CORDIC rotator under a small sequencer.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries an opcode in tuser. A wheel speed
// request updates the linear speed and the turn rate; a time step request
// advances x, y and the heading, using a CORDIC rotator for the cosine and
// sine of the heading before the step. Every request returns one result on
// the master stream with the pose and the speeds.
// A wheel speed request passes through the steps for the two wheel products,
// the speed sum and the turn rate; a time step request passes through the
// CORDIC iterations, one per cycle, and the steps of the shared multiplier.
// The input is ready again in the cycle in which the new result first shows
// as valid on the master stream.
// The result register holds while the receiver stalls; a new request is still
// taken, and its result waits in the last sequencer step until the register
// is free. Reset clears the pose and the speeds to zero and loads the default
// speed scale and reciprocal wheel track. Configuration writes are taken in
// any cycle and should be made while the block is idle.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int POSE_BITS    = DEF_POSE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // left_wheel_speed [15:0], right_wheel_speed [31:16], elapsed_time [47:32]
    input  logic [47:0]           i_s_axis_tdata,
    // opcode [0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // pos_x [31:0], pos_y [63:32], heading_angle [95:64], linear_speed [127:96],
    // turn_rate [159:128]
    output logic [159:0]          o_m_axis_tdata
);

    localparam int          SUM_W = (POSE_BITS > 27 ? POSE_BITS : 27) + 1;
    localparam logic [4:0]  LAST  = 5'(CORDIC_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_WL, S_WR, S_SUM, S_YAW1, S_YAW2,
        S_CINIT, S_CROT, S_CFIN,
        S_MX1, S_MX2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    logic [159:0]                r_out_data;

    logic [15:0]                 r_speed_scale;
    logic [23:0]                 r_inv_track;

    logic signed [24:0]          r_speed;
    logic signed [31:0]          r_yaw;
    logic signed [POSE_BITS-1:0] r_x;
    logic signed [POSE_BITS-1:0] r_y;
    logic [31:0]                 r_angle;

    logic signed [15:0]          r_left;
    logic signed [15:0]          r_right;
    logic [15:0]                 r_dt;

    logic signed [24:0]          r_l;
    logic signed [25:0]          r_diff;
    logic signed [33:0]          r_cx;
    logic signed [33:0]          r_cy;
    logic signed [33:0]          r_cz;
    logic [4:0]                  r_cnt;
    logic                        r_flip;
    logic signed [26:0]          r_tx;
    logic signed [26:0]          r_ty;
    logic [15:0]                 r_b;
    logic [47:0]                 r_acc;
    logic signed [65:0]          r_prod;

    logic signed [32:0]          m_a;
    logic signed [32:0]          m_b;

    logic signed [24:0]          w_r;
    logic signed [25:0]          w_lr_sum;
    logic signed [33:0]          w_yaw_full;
    logic signed [31:0]          w_yaw_sat;
    logic signed [26:0]          w_delta;
    logic signed [SUM_W-1:0]     w_sum_x;
    logic signed [SUM_W-1:0]     w_sum_y;
    logic signed [POSE_BITS-1:0] w_sat_x;
    logic signed [POSE_BITS-1:0] w_sat_y;
    logic signed [33:0]          w_sh_x;
    logic signed [33:0]          w_sh_y;
    logic signed [33:0]          w_atan;
    logic [31:0]                 w_fold;
    logic                        w_fold_flip;
    logic [47:0]                 w_ang_sum;
    logic signed [63:0]          w_x64;
    logic signed [63:0]          w_y64;

    function automatic logic signed [POSE_BITS-1:0] sat_pose(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-POSE_BITS:0] top;
        top = v[SUM_W-1:POSE_BITS-1];
        if ((&top) || !(|top)) begin
            return v[POSE_BITS-1:0];
        end
        return {v[SUM_W-1], {(POSE_BITS-1){~v[SUM_W-1]}}};
    endfunction

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_WL: begin
                m_a = 33'(r_left);
                m_b = $signed({17'd0, r_speed_scale});
            end
            S_WR: begin
                m_a = 33'(r_right);
                m_b = $signed({17'd0, r_speed_scale});
            end
            S_YAW1: begin
                m_a = 33'(r_diff);
                m_b = $signed({9'd0, r_inv_track});
            end
            S_MX1: begin
                m_a = 33'(r_speed);
                m_b = r_cx[32:0];
            end
            S_MX2: begin
                m_a = 33'(r_speed);
                m_b = r_cy[32:0];
            end
            S_M3: begin
                m_a = 33'(r_tx);
                m_b = $signed({17'd0, r_dt});
            end
            S_M4: begin
                m_a = 33'(r_ty);
                m_b = $signed({17'd0, r_dt});
            end
            S_M5: begin
                m_a = 33'(r_yaw);
                m_b = $signed({17'd0, r_dt});
            end
            S_M6: begin
                m_a = 33'($signed(r_prod[47:16]));
                m_b = $signed({3'd0, INV_TWO_PI_Q32});
            end
            S_M7: begin
                m_a = $signed({17'd0, r_b});
                m_b = $signed({3'd0, INV_TWO_PI_Q32});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_comb begin
        w_r        = r_prod[32:8];
        w_lr_sum   = 26'(r_l) + 26'(w_r);
        w_yaw_full = r_prod[49:16];
        if ((&w_yaw_full[33:31]) || !(|w_yaw_full[33:31])) begin
            w_yaw_sat = w_yaw_full[31:0];
        end else begin
            w_yaw_sat = {w_yaw_full[33], {31{~w_yaw_full[33]}}};
        end
        w_delta = r_prod[42:16];
        w_sum_x = SUM_W'(r_x) + SUM_W'(w_delta);
        w_sum_y = SUM_W'(r_y) + SUM_W'(w_delta);
        w_sat_x = sat_pose(w_sum_x);
        w_sat_y = sat_pose(w_sum_y);
        w_sh_x  = r_cy >>> r_cnt;
        w_sh_y  = r_cx >>> r_cnt;
        w_atan  = $signed({4'd0, atan_lut(r_cnt)});
        w_fold_flip = (r_angle[31:30] == 2'b01) || (r_angle[31:30] == 2'b10);
        w_fold  = w_fold_flip ? {~r_angle[31], r_angle[30:0]} : r_angle;
        w_ang_sum = r_acc + {18'd0, r_prod[45:16]};
        w_x64   = 64'(r_x);
        w_y64   = 64'(r_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_speed_scale <= SPEED_SCALE_RST;
            r_inv_track   <= INV_TRACK_RST;
            r_speed       <= '0;
            r_yaw         <= '0;
            r_x           <= '0;
            r_y           <= '0;
            r_angle       <= '0;
        end else begin
            r_prod <= m_a * m_b;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SPEED_SCALE: r_speed_scale <= i_cfg_wdata[15:0];
                    CFG_INV_TRACK:   r_inv_track   <= i_cfg_wdata;
                    default:         r_inv_track   <= r_inv_track;
                endcase
            end

            if (r_out_valid && i_m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_left  <= $signed(i_s_axis_tdata[15:0]);
                        r_right <= $signed(i_s_axis_tdata[31:16]);
                        r_dt    <= i_s_axis_tdata[47:32];
                        r_state <= (i_s_axis_tuser == OP_STEP) ? S_CINIT : S_WL;
                    end
                end
                S_WL: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_l     <= r_prod[32:8];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_speed <= w_lr_sum[25:1];
                    r_diff  <= 26'(w_r) - 26'(r_l);
                    r_state <= S_YAW1;
                end
                S_YAW1: begin
                    r_state <= S_YAW2;
                end
                S_YAW2: begin
                    r_yaw   <= w_yaw_sat;
                    r_state <= S_FIN;
                end
                S_CINIT: begin
                    r_cx    <= $signed({2'd0, CORDIC_GAIN_Q30});
                    r_cy    <= '0;
                    r_cz    <= 34'($signed(w_fold));
                    r_flip  <= w_fold_flip;
                    r_cnt   <= '0;
                    r_state <= S_CROT;
                end
                S_CROT: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - w_sh_x;
                        r_cy <= r_cy + w_sh_y;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_sh_x;
                        r_cy <= r_cy - w_sh_y;
                        r_cz <= r_cz + w_atan;
                    end
                    if (r_cnt == LAST) begin
                        r_state <= S_CFIN;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CFIN: begin
                    if (r_flip) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                    r_state <= S_MX1;
                end
                S_MX1: begin
                    r_state <= S_MX2;
                end
                S_MX2: begin
                    r_tx    <= r_prod[56:30];
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_ty    <= r_prod[56:30];
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_x     <= w_sat_x;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_y     <= w_sat_y;
                    r_state <= S_M6;
                end
                S_M6: begin
                    r_b     <= r_prod[15:0];
                    r_state <= S_M7;
                end
                S_M7: begin
                    r_acc   <= r_prod[47:0];
                    r_state <= S_M8;
                end
                S_M8: begin
                    r_angle <= r_angle + w_ang_sum[47:16];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_yaw, 32'(r_speed), r_angle,
                                        w_y64[31:0], w_x64[31:0]};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
